// ===== hdl/history_block_store_unit_defines.svh =====
// Assertion macros for the history block store.
// Included by the top level; needs clk_i and rst_ni in scope.
`ifndef HISTORY_BLOCK_STORE_UNIT_DEFINES_SVH
`define HISTORY_BLOCK_STORE_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define HBS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition holds at every edge out of reset
`define HBS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) 1'b1 |-> (cond)) \
    else $error(msg);

`endif

// ===== hdl/hbs_pkg.sv =====
// Shared types and constants of the history block store.
// No dependencies.
`default_nettype none
package hbs_pkg;

  localparam int unsigned BlockBytes = 8;
  localparam int unsigned IdxW = 4;

  typedef enum logic [2:0] {
    CMD_BEGIN  = 3'd0,
    CMD_DATA   = 3'd1,
    CMD_READ   = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ENT  = 2'd1,
    ST_DROPPED = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_EV_REQ, S_EV_CNT, S_EV_LRD, S_EV_BLK, S_EV_DONE,
    S_BG_CHK, S_BG_SCAN, S_BG_FIN, S_DT_CHK, S_RD_CNT, S_RD_LST, S_RD_BLK,
    S_RD_OUT, S_RESP, S_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [11:0] length_bytes;
    logic [63:0] data_block;
    logic [5:0]  entry_age;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_block;
    logic        last_block;
    logic [6:0]  free_blocks;
    logic [6:0]  entry_count;
  } out_t;

endpackage
`default_nettype wire

// ===== hdl/history_block_store_unit.sv =====
// History block store: entries in fixed blocks tracked by an occupancy map.
// Depends on hbs_pkg, hbs_ram and history_block_store_unit_defines.svh.
//
// Usage: an item transfers on the input channel when in_valid_i is high and
// in_stall_o low; results transfer when out_valid_o is high and out_stall_i
// low. The block works on one item at a time and holds in_stall_o high from
// the transfer until its last result has been taken.
// Steps per item: a simple command passes dispatch, response and transfer;
// a data transfer adds a write step, each plus the output wait. A read passes,
// per block, the list RAM, block RAM, output register, response and transfer.
// A begin scans the occupancy map one block per cycle, and each eviction reads
// the entry's block count, then reads and frees each of its blocks in turn.
// Reset clears the map, the counters and the fill state; the RAMs are not
// cleared, blocks are zeroed when allocated. While the receiver stalls, the
// result holds in the output register and no new item is taken.
`default_nettype none
`include "history_block_store_unit_defines.svh"
module history_block_store_unit
  import hbs_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS           = 64,
  parameter int unsigned MAX_BLOCKS_PER_ENTRY = 15,
  parameter int unsigned MAX_ENTRIES          = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);
  localparam int unsigned BW = $clog2(NUM_BLOCKS);
  localparam int unsigned SW = $clog2(MAX_ENTRIES);
  localparam int unsigned FW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LD = MAX_ENTRIES << IdxW;
  localparam int unsigned Cap =
    (MAX_BLOCKS_PER_ENTRY < NUM_BLOCKS) ? MAX_BLOCKS_PER_ENTRY : NUM_BLOCKS;

  state_e          state_q, state_d;
  in_t             in_q;
  logic            ret_q, ret_d;
  logic [IdxW-1:0] need_q, need_d, n_q, n_d, i_q, i_d, got_q, got_d, pos_q, pos_d;
  logic [BW-1:0]   j_q, j_d;
  logic [SW-1:0]   rslot_q, rslot_d, oldest_q, oldest_d;
  logic [NUM_BLOCKS-1:0] occ_q, occ_d;
  logic [FW-1:0]   free_q, free_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [11:0]     rem_q, rem_d;
  status_e         st_q, st_d;
  logic [63:0]     blk_q, blk_d;
  logic            last_q, last_d;
  out_t            out_q, out_d;

  logic            store_we, list_we, ecnt_we;
  logic [BW-1:0]   store_waddr, store_raddr;
  logic [63:0]     store_wdata, store_rdata;
  logic [SW+IdxW-1:0] list_waddr, list_raddr;
  logic [BW-1:0]   list_wdata, list_rdata;
  logic [SW-1:0]   ecnt_waddr, ecnt_raddr;
  logic [IdxW-1:0] ecnt_wdata, ecnt_rdata;

  hbs_ram #(.Width(64), .Depth(NUM_BLOCKS)) u_store (
    .clk_i, .we_i(store_we), .waddr_i(store_waddr), .wdata_i(store_wdata),
    .raddr_i(store_raddr), .rdata_o(store_rdata));
  hbs_ram #(.Width(BW), .Depth(LD)) u_list (
    .clk_i, .we_i(list_we), .waddr_i(list_waddr), .wdata_i(list_wdata),
    .raddr_i(list_raddr), .rdata_o(list_rdata));
  hbs_ram #(.Width(IdxW), .Depth(MAX_ENTRIES)) u_ecnt (
    .clk_i, .we_i(ecnt_we), .waddr_i(ecnt_waddr), .wdata_i(ecnt_wdata),
    .raddr_i(ecnt_raddr), .rdata_o(ecnt_rdata));

  // slot arithmetic on the entry ring
  logic [SW+1:0] sum_new, sum_newest, sum_age;
  logic [SW-1:0] slot_new, slot_newest, slot_age, oldest_inc;
  logic [9:0]    ceil_blocks;
  logic [IdxW-1:0] need_calc, ecnt_cap;
  logic [3:0]    nbytes;
  logic [63:0]   mask;
  logic          found, scan_end;

  always_comb begin
    sum_new     = (SW+2)'(oldest_q) + (SW+2)'(cnt_q);
    sum_newest  = sum_new - (SW+2)'(1);
    sum_age     = sum_newest - (SW+2)'(in_q.entry_age);
    slot_new    = (sum_new >= (SW+2)'(MAX_ENTRIES)) ?
                  SW'(sum_new - (SW+2)'(MAX_ENTRIES)) : SW'(sum_new);
    slot_newest = (sum_newest >= (SW+2)'(MAX_ENTRIES)) ?
                  SW'(sum_newest - (SW+2)'(MAX_ENTRIES)) : SW'(sum_newest);
    slot_age    = (sum_age >= (SW+2)'(MAX_ENTRIES)) ?
                  SW'(sum_age - (SW+2)'(MAX_ENTRIES)) : SW'(sum_age);
    oldest_inc  = (oldest_q == SW'(MAX_ENTRIES - 1)) ? '0 : oldest_q + SW'(1);
    ceil_blocks = 10'((13'(in_q.length_bytes) + 13'(BlockBytes - 1)) >> 3);
    need_calc   = (ceil_blocks > 10'(Cap)) ? IdxW'(Cap) : ceil_blocks[IdxW-1:0];
    ecnt_cap    = (ecnt_rdata > IdxW'(MAX_BLOCKS_PER_ENTRY)) ?
                  IdxW'(MAX_BLOCKS_PER_ENTRY) : ecnt_rdata;
    nbytes      = (rem_q < 12'(BlockBytes)) ? rem_q[3:0] : 4'(BlockBytes);
    for (int k = 0; k < 8; k++) begin
      mask[k*8 +: 8] = (4'(k) < nbytes) ? 8'hFF : 8'h00;
    end
    found    = !occ_q[j_q];
    scan_end = (found && (got_q + IdxW'(1) == need_q)) || (j_q == BW'(NUM_BLOCKS - 1));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        unique case (in_q.command)
          CMD_BEGIN:  state_d = (cnt_q >= CW'(MAX_ENTRIES)) ? S_EV_REQ : S_BG_CHK;
          CMD_DATA:   state_d = (rem_q == '0 || cnt_q == '0) ? S_RESP : S_DT_CHK;
          CMD_READ:   state_d = (7'(in_q.entry_age) >= 7'(cnt_q)) ? S_RESP : S_RD_CNT;
          CMD_REMOVE: state_d = (cnt_q == '0) ? S_RESP : S_EV_REQ;
          default:    state_d = S_RESP;
        endcase
      end
      S_EV_REQ:  state_d = S_EV_CNT;
      S_EV_CNT:  state_d = (ecnt_cap == '0) ? S_EV_DONE : S_EV_LRD;
      S_EV_LRD:  state_d = S_EV_BLK;
      S_EV_BLK:  state_d = (i_q + IdxW'(1) == n_q) ? S_EV_DONE : S_EV_LRD;
      S_EV_DONE: state_d = ret_q ? S_BG_CHK : S_RESP;
      S_BG_CHK: begin
        if (8'(free_q) < 8'(need_q) && cnt_q != '0) state_d = S_EV_REQ;
        else if (need_q == '0) state_d = S_BG_FIN;
        else state_d = S_BG_SCAN;
      end
      S_BG_SCAN: if (scan_end) state_d = S_BG_FIN;
      S_BG_FIN:  state_d = S_RESP;
      S_DT_CHK:  state_d = S_RESP;
      S_RD_CNT:  state_d = (ecnt_cap == '0) ? S_RESP : S_RD_LST;
      S_RD_LST:  state_d = S_RD_BLK;
      S_RD_BLK:  state_d = S_RD_OUT;
      S_RD_OUT:  state_d = S_RESP;
      S_RESP:    state_d = S_EMIT;
      S_EMIT:    if (!out_stall_i) state_d = last_q ? S_IDLE : S_RD_LST;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath and RAM controls
  always_comb begin
    ret_d = ret_q; need_d = need_q; n_d = n_q; i_d = i_q; got_d = got_q;
    pos_d = pos_q; j_d = j_q; rslot_d = rslot_q; oldest_d = oldest_q;
    occ_d = occ_q; free_d = free_q; cnt_d = cnt_q; rem_d = rem_q;
    st_d = st_q; blk_d = blk_q; last_d = last_q; out_d = out_q;
    store_we = 1'b0; store_waddr = j_q; store_wdata = '0;
    store_raddr = list_rdata;
    list_we = 1'b0; list_waddr = {slot_new, got_q}; list_wdata = j_q;
    list_raddr = {oldest_q, i_q};
    ecnt_we = 1'b0; ecnt_waddr = slot_new; ecnt_wdata = got_q;
    ecnt_raddr = oldest_q;
    unique case (state_q)
      S_IDLE: begin
        st_d = ST_OK; blk_d = '0; last_d = 1'b1; i_d = '0;
      end
      S_DISPATCH: begin
        unique case (in_q.command)
          CMD_BEGIN: begin
            need_d = need_calc; ret_d = 1'b1;
          end
          CMD_DATA: begin
            list_raddr = {slot_newest, pos_q};
            ecnt_raddr = slot_newest;
            if (rem_q == '0 || cnt_q == '0) st_d = ST_DROPPED;
          end
          CMD_READ: begin
            ecnt_raddr = slot_age; rslot_d = slot_age;
            if (7'(in_q.entry_age) >= 7'(cnt_q)) st_d = ST_NO_ENT;
          end
          CMD_REMOVE: begin
            ret_d = 1'b0;
            if (cnt_q == '0) st_d = ST_EMPTY;
          end
          CMD_CLEAR: begin
            occ_d = '0; free_d = FW'(NUM_BLOCKS); oldest_d = '0; cnt_d = '0;
            rem_d = '0; pos_d = '0;
          end
          default: ;
        endcase
      end
      S_EV_REQ: ecnt_raddr = oldest_q;
      S_EV_CNT: begin
        n_d = ecnt_cap; i_d = '0;
      end
      S_EV_LRD: list_raddr = {oldest_q, i_q};
      S_EV_BLK: begin
        occ_d[list_rdata] = 1'b0;
        free_d = free_q + FW'(1);
        i_d = i_q + IdxW'(1);
      end
      S_EV_DONE: begin
        oldest_d = oldest_inc;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          rem_d = '0; pos_d = '0;
        end
      end
      S_BG_CHK: begin
        j_d = '0; got_d = '0;
      end
      S_BG_SCAN: begin
        if (found && got_q != need_q) begin
          occ_d[j_q] = 1'b1;
          free_d = free_q - FW'(1);
          store_we = 1'b1;
          list_we = 1'b1;
          got_d = got_q + IdxW'(1);
        end
        j_d = j_q + BW'(1);
      end
      S_BG_FIN: begin
        ecnt_we = 1'b1;
        cnt_d = cnt_q + CW'(1);
        rem_d = (in_q.length_bytes < 12'({got_q, 3'b000})) ?
                in_q.length_bytes : 12'({got_q, 3'b000});
        pos_d = '0;
      end
      S_DT_CHK: begin
        if (pos_q >= ecnt_rdata || pos_q >= IdxW'(MAX_BLOCKS_PER_ENTRY)) begin
          rem_d = '0; st_d = ST_DROPPED;
        end else begin
          store_we = 1'b1; store_waddr = list_rdata;
          store_wdata = in_q.data_block & mask;
          rem_d = rem_q - 12'(nbytes);
          pos_d = pos_q + IdxW'(1);
        end
      end
      S_RD_CNT: begin
        n_d = ecnt_cap; i_d = '0;
      end
      S_RD_LST: list_raddr = {rslot_q, i_q};
      S_RD_BLK: store_raddr = list_rdata;
      S_RD_OUT: begin
        blk_d = store_rdata;
        last_d = (i_q + IdxW'(1) == n_q);
      end
      S_RESP: begin
        out_d.status      = st_q;
        out_d.read_block  = blk_q;
        out_d.last_block  = last_q;
        out_d.free_blocks = 7'(free_q);
        out_d.entry_count = 7'(cnt_q);
      end
      S_EMIT: if (!out_stall_i && !last_q) i_d = i_q + IdxW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      occ_q    <= '0;
      free_q   <= FW'(NUM_BLOCKS);
      cnt_q    <= '0;
      oldest_q <= '0;
      rem_q    <= '0;
      pos_q    <= '0;
      ret_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      free_q   <= free_d;
      cnt_q    <= cnt_d;
      oldest_q <= oldest_d;
      rem_q    <= rem_d;
      pos_q    <= pos_d;
      ret_q    <= ret_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) in_q <= in_data_i;
    need_q <= need_d; n_q <= n_d; i_q <= i_d; got_q <= got_d; j_q <= j_d;
    rslot_q <= rslot_d; st_q <= st_d; blk_q <= blk_d; last_q <= last_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);
  assign out_data_o  = out_q;

  `HBS_ASSERT_IMP(a_out_blocks_in, out_valid_o, in_stall_o, "input taken during output")
  `HBS_ASSERT_ALWAYS(a_free_range, free_q <= FW'(NUM_BLOCKS), "free count out of range")
  `HBS_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CW'(MAX_ENTRIES), "entry count out of range")
  `HBS_ASSERT_IMP(a_map_free, state_q == S_IDLE,
                  $countones(~occ_q) == 32'(free_q), "map and free count disagree")
endmodule
`default_nettype wire

// ===== hdl/hbs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module hbs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for history_block_store_unit: random and directed commands, results checked
// against a behavioral model of the block store held in a scoreboard class.
// Depends on hbs_pkg and the RTL of history_block_store_unit.
`default_nettype none
module tb_top;
  import hbs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = 64;
  localparam int MAXB = 15;
  localparam int MAXE = 64;
  localparam int CYCLE_LIMIT = 900000;

  class hist_scoreboard;
    logic [63:0] occ;
    logic [63:0] blocks [NBLK];
    logic [5:0]  lists [MAXE][MAXB];
    int          counts [MAXE];
    int          oldest, entries, fill_left, fill_pos;
    out_t        pending [$];
    int          errors;

    function void clear_all();
      occ = '0;
      foreach (blocks[i]) blocks[i] = '0;
      oldest = 0; entries = 0; fill_left = 0; fill_pos = 0;
    endfunction

    function int free_count();
      int n;
      n = 0;
      for (int i = 0; i < NBLK; i++) if (!occ[i]) n++;
      return n;
    endfunction

    function bit drop_oldest();
      int s;
      if (entries == 0) return 0;
      s = oldest;
      for (int i = 0; i < counts[s]; i++) begin
        occ[lists[s][i]] = 1'b0;
        blocks[lists[s][i]] = '0;
      end
      oldest = (s + 1) % MAXE;
      entries--;
      if (entries == 0) begin
        fill_left = 0; fill_pos = 0;
      end
      return 1;
    endfunction

    function void push(status_e st, logic [63:0] blk, bit last);
      out_t r;
      r.status = st;
      r.read_block = blk;
      r.last_block = last;
      r.free_blocks = 7'(free_count());
      r.entry_count = 7'(entries);
      pending.push_back(r);
    endfunction

    function void note_input(in_t it);
      int need, s, got, n, c;
      logic [63:0] mask;
      case (it.command)
        CMD_BEGIN: begin
          need = (int'(it.length_bytes) + 7) / 8;
          if (need > MAXB) need = MAXB;
          if (entries >= MAXE) void'(drop_oldest());
          while (free_count() < need && drop_oldest()) ;
          s = (oldest + entries) % MAXE;
          got = 0;
          for (int i = 0; i < NBLK && got < need; i++) begin
            if (!occ[i]) begin
              occ[i] = 1'b1;
              blocks[i] = '0;
              lists[s][got] = 6'(i);
              got++;
            end
          end
          counts[s] = got;
          entries++;
          fill_left = (it.length_bytes < got * 8) ? it.length_bytes : got * 8;
          fill_pos = 0;
          push(ST_OK, '0, 1);
        end
        CMD_DATA: begin
          if (fill_left == 0 || entries == 0) push(ST_DROPPED, '0, 1);
          else begin
            s = (oldest + entries - 1) % MAXE;
            if (fill_pos >= counts[s]) begin
              fill_left = 0;
              push(ST_DROPPED, '0, 1);
            end else begin
              n = fill_left < 8 ? fill_left : 8;
              mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 1);
              blocks[lists[s][fill_pos]] = it.data_block & mask;
              fill_left -= n;
              fill_pos++;
              push(ST_OK, '0, 1);
            end
          end
        end
        CMD_READ: begin
          if (it.entry_age >= entries) push(ST_NO_ENT, '0, 1);
          else begin
            s = (oldest + entries - 1 - it.entry_age) % MAXE;
            c = counts[s];
            if (c == 0) push(ST_OK, '0, 1);
            else for (int i = 0; i < c; i++) push(ST_OK, blocks[lists[s][i]], i == c - 1);
          end
        end
        CMD_REMOVE: push(drop_oldest() ? ST_OK : ST_EMPTY, '0, 1);
        CMD_CLEAR: begin
          clear_all();
          push(ST_OK, '0, 1);
        end
        default: push(ST_OK, '0, 1);
      endcase
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $error("status exp %0d got %0d", want.status, got.status); errors++;
      end
      if (got.read_block !== want.read_block) begin
        $error("read_block exp %h got %h", want.read_block, got.read_block); errors++;
      end
      if (got.last_block !== want.last_block) begin
        $error("last_block exp %0d got %0d", want.last_block, got.last_block); errors++;
      end
      if (got.free_blocks !== want.free_blocks) begin
        $error("free_blocks exp %0d got %0d", want.free_blocks, got.free_blocks); errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count exp %0d got %0d", want.entry_count, got.entry_count); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_t  in_data_i;
  out_t out_data_o;
  hist_scoreboard sb;
  bit   hold_off;
  int   cycles;

  history_block_store_unit DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_input(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  task automatic send_cmd(cmd_e cmd, int len, logic [63:0] data, int age);
    in_t it;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    it.command = cmd;
    it.length_bytes = 12'(len);
    it.data_block = data;
    it.entry_age = 6'(age);
    in_data_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic store_entry(int len);
    int nblk;
    nblk = (len + 7) / 8;
    if (nblk > MAXB) nblk = MAXB;
    nblk += $urandom_range(0, 1);
    send_cmd(CMD_BEGIN, len, '0, 0);
    for (int i = 0; i < nblk; i++)
      send_cmd(CMD_DATA, 0, rand64(), 0);
  endtask

  initial begin
    int burst;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) out_stall_i <= 1'b1;
      else if ($urandom_range(0, 2) == 0) begin
        burst = $urandom_range(1, 14);
        out_stall_i <= 1'b1;
        repeat (burst) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else out_stall_i <= 1'b0;
    end
  end

  initial begin
    int sel, len;
    cmd_e cmd;
    sb = new();
    sb.clear_all();
    sb.errors = 0;
    cycles = 0;
    hold_off = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed
    send_cmd(CMD_REMOVE, 0, '0, 0);
    send_cmd(CMD_DATA, 0, '1, 0);
    send_cmd(CMD_READ, 0, '0, 63);
    send_cmd(cmd_e'(3'd5), 4095, '1, 63);
    send_cmd(cmd_e'(3'd7), 0, '0, 0);
    store_entry(0);
    send_cmd(CMD_READ, 0, '0, 0);
    store_entry(13);
    send_cmd(CMD_DATA, 0, '1, 0);
    store_entry(4095);
    send_cmd(CMD_READ, 0, '0, 0);
    send_cmd(CMD_READ, 0, '0, 2);
    send_cmd(CMD_BEGIN, 120, '0, 0);
    send_cmd(CMD_REMOVE, 0, '0, 0);
    send_cmd(CMD_REMOVE, 0, '0, 0);
    send_cmd(CMD_DATA, 0, 64'hAAAA_5555_AAAA_5555, 0);
    send_cmd(CMD_CLEAR, 0, '0, 0);
    send_cmd(CMD_READ, 0, '0, 0);

    // fill the table with empty entries, forcing eviction on a full table
    for (int i = 0; i < 66; i++) send_cmd(CMD_BEGIN, 0, '0, 0);
    send_cmd(CMD_READ, 0, '0, 63);
    send_cmd(CMD_CLEAR, 0, '0, 0);

    // receiver holds off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_cmd(CMD_BEGIN, 16, '0, 0);
    join

    for (int n = 0; n < 45; n++) begin
      sel = $urandom_range(0, 19);
      if (sel < 9) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 130);
        store_entry(len);
      end else if (sel < 15) send_cmd(CMD_READ, 0, '0,
                                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                                                                : $urandom_range(0, 8));
      else if (sel < 17) send_cmd(CMD_REMOVE, 0, '0, 0);
      else if (sel == 17) send_cmd(CMD_CLEAR, 0, '0, 0);
      else if (sel == 18) send_cmd(CMD_DATA, 0, rand64(), 0);
      else begin
        cmd = cmd_e'(3'($urandom_range(5, 7)));
        send_cmd(cmd, $urandom_range(0, 4095), rand64(), $urandom_range(0, 63));
      end
    end

    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/hbs_pkg.sv
hdl/hbs_ram.sv
hdl/history_block_store_unit.sv
verif/tb_top.sv
